// File: rtl/fmop_pkg.sv
package fmop_pkg;

    // sizes of the sine table and the envelope arithmetic
    localparam int SINE_ENTRIES_LOG2   = 12;
    localparam int SINE_AMPLITUDE_LOG2 = 12;
    localparam int GAIN_FRACTION_BITS  = 16;

    localparam int DATA_W    = 32;
    localparam int ROM_DEPTH = 1 << SINE_ENTRIES_LOG2;
    localparam int ADDR_W    = SINE_ENTRIES_LOG2;
    localparam int SINE_W    = SINE_AMPLITUDE_LOG2 + 2;
    localparam int GAIN_W    = DATA_W - GAIN_FRACTION_BITS;
    localparam int MUL_W     = DATA_W + GAIN_W;
    localparam int LEN_W     = 24;
    localparam int LEVEL_W   = 31;
    localparam int COUNT_W   = LEN_W + 1;
    localparam int FBG_W     = 16;
    localparam int MODE_W    = 2;
    localparam int REQ_W     = 2;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

    // operator modes, the unused code behaves as plain sine
    localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEEDBACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PHASE_MOD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd7;

    typedef enum logic [PHASE_W-1:0] {
        PH_START    = 3'd0,
        PH_ATTACK   = 3'd1,
        PH_DECAY    = 3'd2,
        PH_SUSTAIN  = 3'd3,
        PH_NOTE_OFF = 3'd4,
        PH_RELEASE  = 3'd5
    } env_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_DIV,
        ST_ADV,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] mod_offset;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     running;
        logic [PHASE_W-1:0]       env_phase;
    } out_item_t;

    // slope divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    typedef logic signed [SINE_W-1:0] sine_rom_t [ROM_DEPTH];

    // Q30 sine generator, evaluated at elaboration only
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    localparam int QUARTER = ROM_DEPTH / 4;

    function automatic logic [63:0] quarter_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        x  = (m * HALF_PI_Q30) >> (SINE_ENTRIES_LOG2 - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++)
        begin
            p = (x2 * t) >> 30;
            t = Q30_ONE - p / TAYLOR_DIV[i];
        end
        t = (x * t) >> 30;
        return ((t << SINE_AMPLITUDE_LOG2) + (64'd1 << 29)) >> 30;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] v;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            q = 2'((k >> (SINE_ENTRIES_LOG2 - 2)) & 3);
            r = 64'(k & (QUARTER - 1));
            m = q[0] ? 64'(QUARTER) - r : r;
            v = quarter_sine(m);
            rom[k] = q[1] ? -SINE_W'(v) : SINE_W'(v);
        end
        return rom;
    endfunction

endpackage

// File: rtl/fm_operator_adsr.sv
// One FM operator with an ADSR envelope. Requests are sample ticks, note-on
// and note-off; each gives exactly one result through a registered output
// stage, so a new request is taken while the last result still waits. Note
// events and ticks while stopped go from ST_IDLE straight to ST_DONE. A
// running tick passes ST_ENV, ST_ADV, ST_MUL1 and ST_DONE in plain sine and
// phase modulation mode, with ST_MUL2 added in feedback mode, set by the
// single read port of the 4096-entry sine ROM and the one shared 32x16
// multiplier. A tick needing a new slope adds ST_DIV for the bit-serial divider.
module fm_operator_adsr import fmop_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  in_item_t             req_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_item_t            res_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [DATA_W-1:0]  phase_step_reg;
    logic [LEN_W-1:0]   attack_len_reg;
    logic [LEN_W-1:0]   decay_len_reg;
    logic [LEN_W-1:0]   release_len_reg;
    logic [LEVEL_W-1:0] peak_gain_reg;
    logic [LEVEL_W-1:0] sustain_level_reg;
    logic [FBG_W-1:0]   feedback_gain_reg;

    // operator state
    fsm_state_t         state_reg;
    fsm_state_t         state_next;
    logic               run_reg;
    env_phase_t         phase_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DATA_W-1:0]  level_reg;
    logic [DATA_W-1:0]  slope_reg;
    logic [DATA_W-1:0]  phase_acc_reg;
    logic [DATA_W-1:0]  fb_sample_reg;

    // working registers
    logic [DATA_W-1:0]        mod_reg;
    logic [DATA_W-1:0]        fbterm_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [SINE_W-1:0] rom_data_reg;
    logic [DATA_W-1:0]        sample_reg;
    logic                     div_neg_reg;
    logic                     res_valid_reg;
    out_item_t                res_data_reg;

    // envelope step decision
    env_phase_t         phase_next;
    logic [COUNT_W-1:0] count_next;
    logic [DATA_W-1:0]  level_next;
    logic [DATA_W-1:0]  slope_next;
    logic               run_next;
    logic               div_go;
    logic               div_neg;
    logic [DATA_W-1:0]  div_num;
    logic [LEN_W-1:0]   div_den;
    logic               to_decay;
    logic               to_sustain;
    logic               to_stop;

    // control strobes
    logic              accept;
    logic              res_free;
    logic              fb_on;
    logic              env_en;
    logic              slope_en;
    logic              adv_en;
    logic              rom_rd_en;
    logic [DATA_W-1:0] rom_phase;
    logic [ADDR_W-1:0] rom_addr;
    logic              sample_en;
    logic              fb_en;
    logic              step_en;
    logic              fbterm_en;
    logic              out_load;

    // shared multiplier
    logic [DATA_W-1:0] mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_full;
    logic [DATA_W-1:0] mul_p;
    logic [DATA_W-1:0] rom_ext;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept   = req_valid && req_ready;
    assign res_free = !res_valid_reg || res_ready;
    assign fb_on    = (mode_reg == MODE_FEEDBACK);
    assign rom_addr = rom_phase[DATA_W-1 -: ADDR_W];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= '0;
            phase_step_reg    <= '0;
            attack_len_reg    <= '0;
            decay_len_reg     <= '0;
            release_len_reg   <= '0;
            peak_gain_reg     <= '0;
            sustain_level_reg <= '0;
            feedback_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:          mode_reg          <= cfg_data[MODE_W-1:0];
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                CFG_ATTACK_LEN:    attack_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_DECAY_LEN:     decay_len_reg     <= cfg_data[LEN_W-1:0];
                CFG_RELEASE_LEN:   release_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_PEAK_GAIN:     peak_gain_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[FBG_W-1:0];
            endcase
        end
    end

    // envelope phase change when the count has run out, with fall-through
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        level_next = level_reg;
        slope_next = slope_reg;
        run_next   = run_reg;
        div_go     = 1'b0;
        div_neg    = 1'b0;
        div_num    = '0;
        div_den    = '0;
        to_decay   = 1'b0;
        to_sustain = 1'b0;
        to_stop    = 1'b0;
        if (count_reg == '0)
        begin
            if (phase_reg == PH_START)
            begin
                phase_next = PH_ATTACK;
                if (attack_len_reg != '0)
                begin
                    div_go     = 1'b1;
                    div_num    = {1'b0, peak_gain_reg};
                    div_den    = attack_len_reg;
                    count_next = {1'b0, attack_len_reg};
                end
                else
                begin
                    to_decay = 1'b1;
                end
            end
            if (phase_reg == PH_ATTACK || to_decay)
            begin
                phase_next = PH_DECAY;
                if (decay_len_reg != '0)
                begin
                    level_next = {1'b0, peak_gain_reg};
                    div_go     = 1'b1;
                    div_neg    = peak_gain_reg > sustain_level_reg;
                    div_num    = div_neg ? {1'b0, peak_gain_reg - sustain_level_reg}
                                         : {1'b0, sustain_level_reg - peak_gain_reg};
                    div_den    = decay_len_reg;
                    count_next = {1'b0, decay_len_reg};
                end
                else
                begin
                    to_sustain = 1'b1;
                end
            end
            if (phase_reg == PH_DECAY || to_sustain)
            begin
                phase_next = PH_SUSTAIN;
                level_next = {1'b0, sustain_level_reg};
                slope_next = '0;
                count_next = '0;
            end
            if (phase_reg == PH_NOTE_OFF)
            begin
                phase_next = PH_RELEASE;
                if (release_len_reg != '0)
                begin
                    div_go     = 1'b1;
                    div_neg    = 1'b1;
                    div_num    = level_reg;
                    div_den    = release_len_reg;
                    count_next = {1'b0, release_len_reg};
                end
                else
                begin
                    to_stop = 1'b1;
                end
            end
            if (phase_reg == PH_RELEASE || to_stop)
            begin
                run_next = 1'b0;
            end
        end
    end

    assign div_req.start    = env_en && div_go;
    assign div_req.dividend = div_num;
    assign div_req.divisor  = div_den;

    fmop_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.req_type == REQ_TICK && run_reg)
                        state_next = ST_ENV;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_ENV:  state_next = div_go ? ST_DIV : ST_ADV;
            ST_DIV:  state_next = div_rsp.done ? ST_ADV : ST_DIV;
            ST_ADV:  state_next = ST_MUL1;
            ST_MUL1: state_next = fb_on ? ST_MUL2 : ST_DONE;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE: state_next = res_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req_ready = 1'b0;
        env_en    = 1'b0;
        slope_en  = 1'b0;
        adv_en    = 1'b0;
        rom_rd_en = 1'b0;
        rom_phase = phase_acc_reg;
        sample_en = 1'b0;
        fb_en     = 1'b0;
        step_en   = 1'b0;
        fbterm_en = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_ENV:
            begin
                env_en    = 1'b1;
                fbterm_en = 1'b1;
                rom_rd_en = 1'b1;
                if (mode_reg == MODE_PHASE_MOD)
                    rom_phase = phase_acc_reg + mod_reg;
            end
            ST_DIV:  slope_en = div_rsp.done;
            ST_ADV:
            begin
                adv_en    = 1'b1;
                rom_rd_en = fb_on;
                rom_phase = phase_acc_reg + fbterm_reg;
            end
            ST_MUL1:
            begin
                sample_en = 1'b1;
                rom_rd_en = fb_on;
                step_en   = !fb_on;
            end
            ST_MUL2:
            begin
                fb_en   = 1'b1;
                step_en = 1'b1;
            end
            ST_DONE: out_load = res_free;
            default: ;
        endcase
    end

    // shared multiplier, low word kept
    assign rom_ext  = {{(DATA_W-SINE_W){rom_data_reg[SINE_W-1]}}, rom_data_reg};
    assign mul_a    = (state_reg == ST_ENV) ? fb_sample_reg : rom_ext;
    assign mul_b    = (state_reg == ST_ENV) ? feedback_gain_reg : gain_reg;
    assign mul_full = {{GAIN_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};
    assign mul_p    = mul_full[DATA_W-1:0];

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            phase_reg     <= PH_START;
            count_reg     <= '0;
            level_reg     <= '0;
            slope_reg     <= '0;
            phase_acc_reg <= '0;
            fb_sample_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // note events
            if (accept)
            begin
                if (req_data.req_type == REQ_NOTE_ON)
                begin
                    run_reg       <= 1'b1;
                    fb_sample_reg <= '0;
                    phase_reg     <= PH_START;
                    count_reg     <= '0;
                    level_reg     <= '0;
                    slope_reg     <= '0;
                end
                else if (req_data.req_type == REQ_NOTE_OFF && run_reg
                         && phase_reg != PH_RELEASE)
                begin
                    phase_reg <= PH_NOTE_OFF;
                    count_reg <= '0;
                end
            end

            // envelope phase entry
            if (env_en)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                level_reg <= level_next;
                slope_reg <= slope_next;
                run_reg   <= run_next;
            end

            if (slope_en)
                slope_reg <= div_neg_reg ? DATA_W'(0) - div_rsp.quotient : div_rsp.quotient;

            // envelope advance
            if (adv_en)
            begin
                level_reg <= level_reg + slope_reg;
                if (phase_reg != PH_SUSTAIN)
                    count_reg <= count_reg - COUNT_W'(1);
            end

            if (fb_en)
                fb_sample_reg <= DATA_W'($signed(mul_p) >>> SINE_AMPLITUDE_LOG2);

            if (step_en)
                phase_acc_reg <= phase_acc_reg + phase_step_reg;

            // output stage
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mod_reg    <= req_data.mod_offset;
            sample_reg <= '0;
        end
        if (fbterm_en)
            fbterm_reg <= mul_p;
        if (env_en)
            div_neg_reg <= div_neg;
        if (adv_en)
            gain_reg <= level_reg[DATA_W-1:GAIN_FRACTION_BITS];
        if (rom_rd_en)
            rom_data_reg <= SINE_ROM[rom_addr];
        if (sample_en)
            sample_reg <= mul_p;
        if (out_load)
        begin
            res_data_reg.sample    <= sample_reg;
            res_data_reg.running   <= run_reg;
            res_data_reg.env_phase <= phase_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// File: rtl/fmop_div.sv
module fmop_div import fmop_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [LEN_W-1:0]  den_reg;

    logic [LEN_W:0]    rem_shift;
    logic [LEN_W+1:0]  diff;
    logic              borrow;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign borrow    = diff[LEN_W+1];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shifter
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? rem_shift[LEN_W-1:0] : diff[LEN_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ~borrow};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
